@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion disabled while the active-low reset is low
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ design/brs_pkg.sv @@
// Types and constants for the bounded range segmenter
`timescale 1ns / 1ps
package brs_pkg;
    localparam int BRS_QUEUE_DEPTH = 1024;
    localparam int IDX_W = 16;
    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [IDX_W-1:0] index_t;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_PUSH,
        Q_POP,
        Q_CLEAR
    } q_op_t;

    typedef enum logic [1:0] {
        C_HOLD,
        C_PUSH,
        C_SHIFT,
        C_CLEAR
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_BREAK,
        ST_CHECK,
        ST_TRIM,
        ST_FINISH
    } state_t;
endpackage

@@ design/bounded_range_segmenter_top.sv @@
// Bounded range segmenter top level: control sequencer, deques and result register
`timescale 1ns / 1ps
// Splits a stream of signed samples into maximal index segments whose max-min
// spread stays within the configured limit. On a limit break the sequencer
// emits the closed segment, then advances the left edge one step at a time,
// trimming stale front entries from both deques in parallel after each step,
// until the spread holds again. A waiting result word stalls the sequencer
// only when a new word is due. An item marked is_last that breaks the limit
// emits two words. The pace is set by the edge-advance loop in the sequencer;
// the max and min deques are rows of cells that pop any number of entries in
// the same cycle as a push. A result word sits in an output register; a word
// with seg_final low is always followed by one with it high from the same
// sample.
module bounded_range_segmenter_top import brs_pkg::*; #(
    parameter int QUEUE_DEPTH = BRS_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                s_is_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [IDX_W-1:0]    m_seg_start,
    output logic [IDX_W-1:0]    m_seg_end,
    output logic                m_seg_final,
    output logic                m_overflow
);
    state_t state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg;
    index_t edge_reg, edge_next;
    index_t cur_reg, cur_next;
    logic   last_reg, last_next;
    logic   ovf_reg, ovf_next;

    logic   out_valid_reg, out_valid_next;
    index_t out_start_reg, out_start_next;
    index_t out_end_reg, out_end_next;
    logic   out_final_reg, out_final_next;
    logic   out_ovf_reg, out_ovf_next;

    q_op_t  max_op, min_op;
    logic   max_fv, min_fv, max_ovf, min_ovf;
    sample_t max_fval, min_fval;
    index_t  max_fidx, min_fidx;

    logic   accept, out_free, over, max_trim, min_trim;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0] spread;
    index_t edge_age;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    assign diff   = {max_fval[SAMPLE_W-1], max_fval} - {min_fval[SAMPLE_W-1], min_fval};
    assign spread = (!max_fv || !min_fv) ? '0 :
                    (diff < 0) ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
    assign over   = spread > {1'b0, limit_reg};

    // ages measured back from the current index, modulo the index range
    assign edge_age = cur_reg - edge_reg;
    assign max_trim = max_fv && ((cur_reg - max_fidx) > edge_age);
    assign min_trim = min_fv && ((cur_reg - min_fidx) > edge_age);

    brs_deque #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_max_q (
        .aclk (aclk), .aresetn (aresetn), .is_max (1'b1), .op (max_op),
        .new_val (s_sample), .new_idx (cur_reg),
        .front_valid (max_fv), .front_val (max_fval), .front_idx (max_fidx),
        .overflow_hit (max_ovf)
    );

    brs_deque #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_min_q (
        .aclk (aclk), .aresetn (aresetn), .is_max (1'b0), .op (min_op),
        .new_val (s_sample), .new_idx (cur_reg),
        .front_valid (min_fv), .front_val (min_fval), .front_idx (min_fidx),
        .overflow_hit (min_ovf)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_FIRST;
            ST_FIRST:  state_next = over ? ST_BREAK : ST_FINISH;
            ST_BREAK:  if (out_free) state_next = ST_CHECK;
            ST_CHECK:  state_next = (over && edge_reg != cur_reg) ? ST_TRIM : ST_FINISH;
            ST_TRIM:   if (!max_trim && !min_trim) state_next = ST_CHECK;
            ST_FINISH: if (!last_reg || out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath control and result register
    always_comb begin
        max_op         = Q_IDLE;
        min_op         = Q_IDLE;
        edge_next      = edge_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    max_op    = Q_PUSH;
                    min_op    = Q_PUSH;
                    last_next = s_is_last;
                    ovf_next  = ovf_reg || max_ovf || min_ovf;
                end
            end
            ST_BREAK: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_start_next = edge_reg;
                    out_end_next   = cur_reg - index_t'(1);
                    out_final_next = !last_reg;
                    out_ovf_next   = ovf_reg;
                end
            end
            ST_CHECK: begin
                if (over && edge_reg != cur_reg) edge_next = edge_reg + index_t'(1);
            end
            ST_TRIM: begin
                if (max_trim) max_op = Q_POP;
                if (min_trim) min_op = Q_POP;
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    cur_next = cur_reg + index_t'(1);
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_start_next = edge_reg;
                    out_end_next   = cur_reg;
                    out_final_next = 1'b1;
                    out_ovf_next   = ovf_reg;
                    max_op    = Q_CLEAR;
                    min_op    = Q_CLEAR;
                    edge_next = '0;
                    cur_next  = '0;
                    ovf_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            limit_reg     <= '0;
            edge_reg      <= '0;
            cur_reg       <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
            edge_reg      <= edge_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_final_reg <= out_final_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_seg_start = out_start_reg;
    assign m_seg_end   = out_end_reg;
    assign m_seg_final = out_final_reg;
    assign m_overflow  = out_ovf_reg;
endmodule

@@ design/brs_cell.sv @@
// One deque cell: holds an index/value pair and shifts toward the front
`timescale 1ns / 1ps
module brs_cell import brs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     is_max,
    input  cell_op_t cell_op,
    input  sample_t  new_val,
    input  index_t   new_idx,
    input  logic     prev_keep,
    input  logic     nb_valid,
    input  sample_t  nb_val,
    input  index_t   nb_idx,
    output logic     keep,
    output logic     valid,
    output sample_t  val,
    output index_t   idx
);
    logic    valid_reg, valid_next;
    sample_t val_reg, val_next;
    index_t  idx_reg, idx_next;

    // entry survives the push if strictly beyond the new sample
    assign keep = valid_reg && (is_max ? (new_val < val_reg) : (new_val > val_reg));

    always_comb begin
        valid_next = valid_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        case (cell_op)
            C_PUSH: begin
                if (!keep) begin
                    if (prev_keep) begin
                        valid_next = 1'b1;
                        val_next   = new_val;
                        idx_next   = new_idx;
                    end else begin
                        valid_next = 1'b0;
                    end
                end
            end
            C_SHIFT: begin
                valid_next = nb_valid;
                val_next   = nb_val;
                idx_next   = nb_idx;
            end
            C_CLEAR: valid_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        val_reg <= val_next;
        idx_reg <= idx_next;
    end

    assign valid = valid_reg;
    assign val   = val_reg;
    assign idx   = idx_reg;
endmodule

@@ design/brs_deque.sv @@
// Monotonic deque built as a row of cells, front at cell zero
`timescale 1ns / 1ps
module brs_deque import brs_pkg::*; #(
    parameter int QUEUE_DEPTH = BRS_QUEUE_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    is_max,
    input  q_op_t   op,
    input  sample_t new_val,
    input  index_t  new_idx,
    output logic    front_valid,
    output sample_t front_val,
    output index_t  front_idx,
    output logic    overflow_hit
);
    logic    keep  [QUEUE_DEPTH];
    logic    valid [QUEUE_DEPTH];
    sample_t val   [QUEUE_DEPTH];
    index_t  idx   [QUEUE_DEPTH];
    cell_op_t cell_op;

    // full and nothing popped: drop the front, new entry enters at the back
    assign overflow_hit = (op == Q_PUSH) && keep[QUEUE_DEPTH-1];

    always_comb begin
        case (op)
            Q_PUSH:  cell_op = overflow_hit ? C_SHIFT : C_PUSH;
            Q_POP:   cell_op = C_SHIFT;
            Q_CLEAR: cell_op = C_CLEAR;
            default: cell_op = C_HOLD;
        endcase
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic    prev_keep;
        logic    nb_valid;
        sample_t nb_val;
        index_t  nb_idx;

        if (i == 0) begin : g_first
            assign prev_keep = 1'b1;
        end else begin : g_mid
            assign prev_keep = keep[i-1];
        end

        if (i == QUEUE_DEPTH-1) begin : g_last
            assign nb_valid = overflow_hit;
            assign nb_val   = new_val;
            assign nb_idx   = new_idx;
        end else begin : g_inner
            assign nb_valid = valid[i+1];
            assign nb_val   = val[i+1];
            assign nb_idx   = idx[i+1];
        end

        brs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .is_max    (is_max),
            .cell_op   (cell_op),
            .new_val   (new_val),
            .new_idx   (new_idx),
            .prev_keep (prev_keep),
            .nb_valid  (nb_valid),
            .nb_val    (nb_val),
            .nb_idx    (nb_idx),
            .keep      (keep[i]),
            .valid     (valid[i]),
            .val       (val[i]),
            .idx       (idx[i])
        );
    end

    assign front_valid = valid[0];
    assign front_val   = val[0];
    assign front_idx   = idx[0];
endmodule

@@ design/brs_checker.sv @@
// Port-level checker for the segmenter top level, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brs_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_seg_final
);
    // a stalled result word stays up
    `ASSERT_CLK(a_m_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)
    // one sample at a time
    `ASSERT_CLK(a_one_item, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    // a non-final word means the same sample still owes its final word
    `ASSERT_CLK(a_pending_final, aclk, aresetn, (m_valid && !m_seg_final) |-> !s_ready)
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
endmodule

bind bounded_range_segmenter_top brs_checker u_brs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_seg_final (m_seg_final)
);

@@ tb/bounded_range_segmenter_top_tb.sv @@
// Self-checking testbench for the bounded range segmenter top level
`timescale 1ns / 1ps
module bounded_range_segmenter_top_tb;
    import brs_pkg::*;

    localparam int DEPTH = BRS_QUEUE_DEPTH;
    localparam int IDX_MOD = 65536;
    localparam int STALL_LIMIT = 400000;
    localparam int SETTLE = 20;
    localparam int MAXQ = 0;
    localparam int MINQ = 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_last;
    } sample_word_t;

    typedef struct {
        logic [IDX_W-1:0] seg_start;
        logic [IDX_W-1:0] seg_end;
        logic             seg_final;
        logic             overflow;
    } segment_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic s_is_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [IDX_W-1:0] m_seg_start;
    logic [IDX_W-1:0] m_seg_end;
    logic m_seg_final;
    logic m_overflow;

    sample_word_t pending_samples[$];
    segment_word_t expected_segments[$];
    int errors = 0;
    bit quiet = 1'b0;
    int s_gap = 0;
    int m_gap = 0;
    int stall_cycles = 0;

    // predictor state: deque 0 tracks the maximum, deque 1 the minimum
    int dq_val[2][DEPTH];
    int dq_idx[2][DEPTH];
    int dq_head[2];
    int dq_count[2];
    int seg_left;
    int seg_cur;
    bit seg_ovf;
    int spread_limit;

    bounded_range_segmenter_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample), .s_is_last(s_is_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_seg_start(m_seg_start),
        .m_seg_end(m_seg_end), .m_seg_final(m_seg_final), .m_overflow(m_overflow)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int dq_slot(int q, int k);
        return (dq_head[q] + k) % DEPTH;
    endfunction

    function automatic int sample_age(int idx);
        return (seg_cur + IDX_MOD - idx) % IDX_MOD;
    endfunction

    function automatic void dq_push(int q, int v, int idx);
        int b;
        while (dq_count[q] > 0) begin
            b = dq_val[q][dq_slot(q, dq_count[q] - 1)];
            if ((q == MAXQ) ? (v >= b) : (v <= b)) dq_count[q]--;
            else break;
        end
        if (dq_count[q] >= DEPTH) begin
            dq_head[q] = (dq_head[q] + 1) % DEPTH;
            dq_count[q]--;
            seg_ovf = 1'b1;
        end
        dq_val[q][dq_slot(q, dq_count[q])] = v;
        dq_idx[q][dq_slot(q, dq_count[q])] = idx;
        dq_count[q]++;
    endfunction

    function automatic void dq_trim(int q);
        int edge_age;
        edge_age = sample_age(seg_left);
        while (dq_count[q] > 0 && sample_age(dq_idx[q][dq_head[q]]) > edge_age) begin
            dq_head[q] = (dq_head[q] + 1) % DEPTH;
            dq_count[q]--;
        end
    endfunction

    function automatic int window_spread();
        int d;
        if (dq_count[MAXQ] == 0 || dq_count[MINQ] == 0) return 0;
        d = dq_val[MAXQ][dq_head[MAXQ]] - dq_val[MINQ][dq_head[MINQ]];
        return (d < 0) ? -d : d;
    endfunction

    function automatic void clear_stream();
        dq_head[MAXQ] = 0; dq_count[MAXQ] = 0;
        dq_head[MINQ] = 0; dq_count[MINQ] = 0;
        seg_left = 0; seg_cur = 0; seg_ovf = 1'b0;
    endfunction

    function automatic void push_segment(int s, int e, bit fin);
        segment_word_t w;
        w.seg_start = s[IDX_W-1:0];
        w.seg_end = e[IDX_W-1:0];
        w.seg_final = fin;
        w.overflow = seg_ovf;
        expected_segments.insert(expected_segments.size(), w);
    endfunction

    function automatic void predict_segments(sample_word_t w);
        int v;
        int idx;
        v = int'(w.sample);
        idx = seg_cur;
        dq_push(MAXQ, v, idx);
        dq_push(MINQ, v, idx);
        if (window_spread() > spread_limit) begin
            push_segment(seg_left, (idx + IDX_MOD - 1) % IDX_MOD, !w.is_last);
            while (window_spread() > spread_limit && seg_left != idx) begin
                seg_left = (seg_left + 1) % IDX_MOD;
                dq_trim(MINQ);
                dq_trim(MAXQ);
            end
        end
        if (w.is_last) begin
            push_segment(seg_left, idx, 1'b1);
            clear_stream();
        end else begin
            seg_cur = (idx + 1) % IDX_MOD;
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_segments('{s_sample, s_is_last});
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    s_gap <= $urandom_range(0, 17);
                    s_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    sample_word_t w;
                    w = pending_samples[0];
                    pending_samples.delete(0);
                    s_sample <= w.sample;
                    s_is_last <= w.is_last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_segments.size() == 0) begin
                    $display("%0t: unexpected word start=%0d end=%0d final=%0b ovf=%0b",
                             $time, m_seg_start, m_seg_end, m_seg_final, m_overflow);
                    errors++;
                end else begin
                    segment_word_t e;
                    e = expected_segments[0];
                    expected_segments.delete(0);
                    if (m_seg_start !== e.seg_start) begin
                        $display("%0t: seg_start expected %0d actual %0d",
                                 $time, e.seg_start, m_seg_start);
                        errors++;
                    end
                    if (m_seg_end !== e.seg_end) begin
                        $display("%0t: seg_end expected %0d actual %0d",
                                 $time, e.seg_end, m_seg_end);
                        errors++;
                    end
                    if (m_seg_final !== e.seg_final) begin
                        $display("%0t: seg_final expected %0b actual %0b",
                                 $time, e.seg_final, m_seg_final);
                        errors++;
                    end
                    if (m_overflow !== e.overflow) begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, e.overflow, m_overflow);
                        errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_gap <= $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_sample(int v, bit last);
        sample_word_t w;
        w.sample = v[SAMPLE_W-1:0];
        w.is_last = last;
        pending_samples.insert(pending_samples.size(), w);
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_samples.size() > 0 || s_valid || expected_segments.size() > 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_limit(int lim);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lim[LIMIT_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        spread_limit = lim;
    endtask

    // random stream: mostly values near a drifting base, some full-range noise
    task automatic add_stream(int len, int jitter);
        int base;
        int v;
        base = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 65535) - 32768;
            else v = base + $urandom_range(0, 2 * jitter) - jitter;
            if ($urandom_range(0, 5) == 0) base = base + $urandom_range(0, 2 * jitter) - jitter;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            add_sample(v, i == len - 1);
        end
    endtask

    initial begin
        int lims[5];
        int lim;
        int cnt;
        clear_stream();
        spread_limit = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit of zero: extremes, single-word streams, break on the last word
        add_sample(32767, 1'b1);
        add_sample(-32768, 1'b1);
        add_sample(0, 1'b0);
        add_sample(0, 1'b0);
        add_sample(32767, 1'b0);
        add_sample(-32768, 1'b0);
        add_sample(-32768, 1'b0);
        add_sample(21845, 1'b0);
        add_sample(-21846, 1'b1);
        add_sample(5, 1'b0);
        add_sample(5, 1'b1);
        drain();

        set_limit(1);
        add_sample(0, 1'b0);
        add_sample(1, 1'b0);
        add_sample(2, 1'b0);
        add_sample(1, 1'b0);
        add_sample(-1, 1'b0);
        add_sample(-2, 1'b1);
        drain();

        // monotonic ramp overfills the min deque and sets the sticky flag
        set_limit(65535);
        for (int i = 0; i < 1030; i++) add_sample(-32768 + i * 50, i == 1029);
        add_sample(-32768, 1'b0);
        add_sample(32767, 1'b1);
        drain();

        lims = '{0, 1, 65535, 255, 4000};
        cnt = 0;
        while (cnt < 150) begin
            lim = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                              : lims[$urandom_range(0, 4)];
            set_limit(lim);
            for (int k = 0; k < 6; k++) begin
                int len;
                len = $urandom_range(1, 12);
                add_stream(len, (lim < 8) ? 4 : lim / 2 + 1);
                cnt += len;
            end
            drain();
        end

        quiet = 1'b1;
        set_limit(300);
        for (int k = 0; k < 3; k++) add_stream($urandom_range(5, 30), 200);
        drain();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/brs_pkg.sv
design/brs_cell.sv
design/brs_deque.sv
design/bounded_range_segmenter_top.sv
design/brs_checker.sv
tb/bounded_range_segmenter_top_tb.sv
